// ===== rtl/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

    // widths of the transaction fields
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EOF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 3'd4;

    // configuration reset values
    localparam logic [BYTE_W-1:0] SOF_RST     = 8'h7E;
    localparam logic [BYTE_W-1:0] EOF_RST     = 8'h7C;
    localparam logic [BYTE_W-1:0] ESC_RST     = 8'h7D;
    localparam logic [BYTE_W-1:0] MASK_RST    = 8'h20;
    localparam logic [BYTE_W-1:0] MAX_LEN_RST = 8'hFF;

    // crc-8 generator polynomial and top bit
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;

    // receiver phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_LEN      = 5'b00010,
        PH_PAYLOAD  = 5'b00100,
        PH_CRC      = 5'b01000,
        PH_WAIT_EOF = 5'b10000
    } phase_t;

    // configuration registers as seen by the deframer
    typedef struct packed {
        logic [BYTE_W-1:0] sof_byte;
        logic [BYTE_W-1:0] eof_byte;
        logic [BYTE_W-1:0] esc_byte;
        logic [BYTE_W-1:0] esc_mask;
        logic [BYTE_W-1:0] max_payload_len;
    } cfg_t;

    // one byte of crc-8, msb first
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] acc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = acc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_MSB) != '0)
            begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sfd_if.sv =====
`default_nettype none

// received byte channel
interface sfd_rx_if;
    logic                      valid;
    logic                      ready;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// decode result channel
interface sfd_res_if;
    logic                        valid;
    logic                        ready;
    logic [sfd_pkg::STATUS_W-1:0] status;
    logic                        byte_valid;
    logic [sfd_pkg::BYTE_W-1:0]   data_byte;
    logic [sfd_pkg::BYTE_W-1:0]   byte_index;

    modport source (output valid, output status, output byte_valid, output data_byte,
                    output byte_index, input ready);
    modport sink   (input valid, input status, input byte_valid, input data_byte,
                    input byte_index, output ready);
endinterface

// configuration write channel
interface sfd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sfd_pkg::CFG_IDX_W-1:0] index;
    logic [sfd_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfd_cfg_regs.sv =====
`default_nettype none

module sfd_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    sfd_cfg_if.sink            cfg,
    output sfd_pkg::cfg_t      regs
);

    sfd_pkg::cfg_t regs_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register file, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.sof_byte        <= sfd_pkg::SOF_RST;
            regs_reg.eof_byte        <= sfd_pkg::EOF_RST;
            regs_reg.esc_byte        <= sfd_pkg::ESC_RST;
            regs_reg.esc_mask        <= sfd_pkg::MASK_RST;
            regs_reg.max_payload_len <= sfd_pkg::MAX_LEN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                sfd_pkg::REG_SOF:     regs_reg.sof_byte        <= cfg.data;
                sfd_pkg::REG_EOF:     regs_reg.eof_byte        <= cfg.data;
                sfd_pkg::REG_ESC:     regs_reg.esc_byte        <= cfg.data;
                sfd_pkg::REG_MASK:    regs_reg.esc_mask        <= cfg.data;
                sfd_pkg::REG_MAX_LEN: regs_reg.max_payload_len <= cfg.data;
                default:              ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfd_deframer.sv =====
`default_nettype none

module sfd_deframer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  sfd_pkg::cfg_t      regs,
    sfd_rx_if.sink             rx,
    sfd_res_if.source          res
);

    // input register
    logic                       in_valid_reg;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte_reg;

    // frame state
    sfd_pkg::phase_t            phase_reg, phase_next;
    logic                       escape_pending_reg, escape_pending_next;
    logic [sfd_pkg::BYTE_W-1:0] expected_len_reg, expected_len_next;
    logic [sfd_pkg::BYTE_W-1:0] received_count_reg, received_count_next;
    logic [sfd_pkg::BYTE_W-1:0] crc_accum_reg, crc_accum_next;

    // result register
    logic                         out_valid_reg;
    logic [sfd_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         byte_valid_reg, byte_valid_next;
    logic [sfd_pkg::BYTE_W-1:0]   data_byte_reg, data_byte_next;
    logic [sfd_pkg::BYTE_W-1:0]   byte_index_reg, byte_index_next;

    logic                       out_free;
    logic                       fire;
    logic                       rx_take;
    logic [sfd_pkg::BYTE_W-1:0] value;
    logic [sfd_pkg::BYTE_W-1:0] count_inc;

    // handshake: input register refills while a result waits
    assign out_free = !out_valid_reg || res.ready;
    assign fire     = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || out_free;
    assign rx_take  = rx.valid && rx.ready;

    assign res.valid      = out_valid_reg;
    assign res.status     = status_reg;
    assign res.byte_valid = byte_valid_reg;
    assign res.data_byte  = data_byte_reg;
    assign res.byte_index = byte_index_reg;

    // unescaped byte value and next payload count
    assign value     = escape_pending_reg ? (rx_byte_reg ^ regs.esc_mask) : rx_byte_reg;
    assign count_inc = received_count_reg + 8'd1;

    // decode one byte
    always_comb
    begin
        phase_next          = phase_reg;
        escape_pending_next = escape_pending_reg;
        expected_len_next   = expected_len_reg;
        received_count_next = received_count_reg;
        crc_accum_next      = crc_accum_reg;
        status_next         = sfd_pkg::ST_NONE;
        byte_valid_next     = 1'b0;
        data_byte_next      = '0;
        byte_index_next     = '0;

        priority if (rx_byte_reg == regs.sof_byte)
        begin
            escape_pending_next = 1'b0;
            expected_len_next   = '0;
            received_count_next = '0;
            crc_accum_next      = '0;
            phase_next          = sfd_pkg::PH_LEN;
        end
        else if (phase_reg == sfd_pkg::PH_IDLE)
        begin
            phase_next = sfd_pkg::PH_IDLE;
        end
        else if (rx_byte_reg == regs.eof_byte && !escape_pending_reg)
        begin
            status_next = (phase_reg == sfd_pkg::PH_WAIT_EOF) ? sfd_pkg::ST_OK
                                                              : sfd_pkg::ST_ERR;
            phase_next  = sfd_pkg::PH_IDLE;
        end
        else if (!escape_pending_reg && rx_byte_reg == regs.esc_byte)
        begin
            escape_pending_next = 1'b1;
        end
        else
        begin
            escape_pending_next = 1'b0;
            unique case (phase_reg)
                sfd_pkg::PH_LEN:
                begin
                    expected_len_next = value;
                    if (value > regs.max_payload_len)
                    begin
                        phase_next  = sfd_pkg::PH_IDLE;
                        status_next = sfd_pkg::ST_ERR;
                    end
                    else
                    begin
                        received_count_next = '0;
                        crc_accum_next      = sfd_pkg::crc8_byte('0, value);
                        phase_next          = (value == '0) ? sfd_pkg::PH_CRC
                                                            : sfd_pkg::PH_PAYLOAD;
                    end
                end
                sfd_pkg::PH_PAYLOAD:
                begin
                    byte_valid_next     = 1'b1;
                    data_byte_next      = value;
                    byte_index_next     = received_count_reg;
                    received_count_next = count_inc;
                    crc_accum_next      = sfd_pkg::crc8_byte(crc_accum_reg, value);
                    if (count_inc == expected_len_reg)
                    begin
                        phase_next = sfd_pkg::PH_CRC;
                    end
                end
                sfd_pkg::PH_CRC:
                begin
                    if (value != crc_accum_reg)
                    begin
                        phase_next  = sfd_pkg::PH_IDLE;
                        status_next = sfd_pkg::ST_ERR;
                    end
                    else
                    begin
                        phase_next = sfd_pkg::PH_WAIT_EOF;
                    end
                end
                default:
                begin
                    // extra data after the crc, or a corrupt phase
                    phase_next  = sfd_pkg::PH_IDLE;
                    status_next = sfd_pkg::ST_ERR;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= sfd_pkg::PH_IDLE;
            escape_pending_reg <= 1'b0;
            expected_len_reg   <= '0;
            received_count_reg <= '0;
            crc_accum_reg      <= '0;
        end
        else
        begin
            if (rx_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                phase_reg          <= phase_next;
                escape_pending_reg <= escape_pending_next;
                expected_len_reg   <= expected_len_next;
                received_count_reg <= received_count_next;
                crc_accum_reg      <= crc_accum_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            rx_byte_reg <= rx.rx_byte;
        end
        if (fire)
        begin
            status_reg     <= status_next;
            byte_valid_reg <= byte_valid_next;
            data_byte_reg  <= data_byte_next;
            byte_index_reg <= byte_index_next;
        end
    end

`ifndef ASSERT_OFF
    // inside the payload the count stays below the length
    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sfd_pkg::PH_PAYLOAD) |-> (received_count_reg < expected_len_reg))
        else $error("payload count reached frame length");

    // an escape never survives into idle
    a_idle_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sfd_pkg::PH_IDLE) |-> !escape_pending_reg)
        else $error("escape pending while idle");

    // a payload byte only comes from the payload phase and carries no status
    a_byte_from_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && byte_valid_next) |->
            (phase_reg == sfd_pkg::PH_PAYLOAD && status_next == sfd_pkg::ST_NONE))
        else $error("payload byte outside payload phase");

    // a good frame ends in idle
    a_ok_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status_next == sfd_pkg::ST_OK) |=> (phase_reg == sfd_pkg::PH_IDLE))
        else $error("frame completion did not return to idle");

    // a byte with no free slot is never dropped
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(rx_byte_reg)))
        else $error("held input byte lost");
`endif

endmodule

`default_nettype wire

// ===== rtl/stuffed_frame_decoder_crc8.sv =====
`default_nettype none

// Byte-stuffed frame decoder with CRC-8. Each received byte transaction on rx gives
// exactly one result transaction on res: status (0 nothing, 1 frame good, 2 frame
// error) and, for payload bytes, the unescaped byte with its index in the frame.
// Frames are start marker, length, payload, CRC, end marker; CRC-8 (poly 0x07,
// init 0, msb first) covers length and payload. Markers, escape mask and maximum
// length are set through cfg (0 start, 1 end, 2 escape, 3 mask, 4 max length) and
// should only be written while no byte is in flight. Throughput is one byte per
// clock while res accepts results: an accepted byte is held in the input register,
// decoded from there, CRC update included, and written into the result register,
// from which its result is offered on res. While a result waits on res the input
// register takes at most one more byte, then rx.ready stays low until res accepts.
module stuffed_frame_decoder_crc8 (
    input  wire logic clk,
    input  wire logic rst_n,
    sfd_rx_if.sink    rx,
    sfd_res_if.source res,
    sfd_cfg_if.sink   cfg
);

    sfd_pkg::cfg_t regs;

    // configuration registers
    sfd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // deframing datapath
    sfd_deframer u_deframer (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .rx    (rx),
        .res   (res)
    );

endmodule

`default_nettype wire
